// ===== rtl/ebct_pkg.sv =====
`timescale 1ns / 1ps
package ebct_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int NUM_CORNERS  = 8;
  localparam int TRIG_W       = 32;
  localparam int PROD_W       = 64;
  localparam int CORDIC_STEPS = 28;
  localparam int TRIG_FRAC    = 28;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 32'sd163008219;
  localparam logic signed [TRIG_W-1:0] ANG_PI          = 32'sd843314857;
  localparam logic signed [TRIG_W-1:0] ANG_HALF_PI     = 32'sd421657428;
  localparam logic signed [PROD_W-1:0] ROUND_HALF      = 64'sd134217728;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic [30:0]        half_width;
    logic [30:0]        half_length;
    logic [30:0]        half_height;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } box_t;

  typedef struct packed {
    logic [2:0]                      corner_index;
    logic signed [COORD_WIDTH-1:0]   corner_x;
    logic signed [COORD_WIDTH-1:0]   corner_y;
    logic signed [COORD_WIDTH-1:0]   corner_z;
    logic                            last_corner;
  } corner_t;

  // sines and cosines in Q.28 plus the box fields riding along
  typedef struct packed {
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] cr;
    box_t                     bx;
  } trig_t;

  function automatic logic signed [TRIG_W-1:0] atan_val(input int i);
    logic signed [TRIG_W-1:0] r;
    case (i)
      0:       r = 32'sd210828714;
      1:       r = 32'sd124459457;
      2:       r = 32'sd65760959;
      3:       r = 32'sd33381290;
      4:       r = 32'sd16755422;
      5:       r = 32'sd8385879;
      6:       r = 32'sd4193963;
      7:       r = 32'sd2097109;
      8:       r = 32'sd1048571;
      9:       r = 32'sd524287;
      default: r = TRIG_W'(64'sd1 <<< (CORDIC_STEPS - i));
    endcase
    return r;
  endfunction

  // Q.28 product, round half up
  function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b) + ROUND_HALF;
    return p[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
  endfunction

endpackage

// ===== rtl/ebct_cordic.sv =====
`timescale 1ns / 1ps
module ebct_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           box_valid,
  output logic           box_ready,
  input  ebct_pkg::box_t box_data,
  output logic           trig_valid,
  input  logic           trig_ready,
  output ebct_pkg::trig_t trig_data
);
  import ebct_pkg::*;

  localparam int NS = CORDIC_STEPS + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic signed [TRIG_W-1:0] xs [NS][3];
  logic signed [TRIG_W-1:0] ys [NS][3];
  logic signed [TRIG_W-1:0] zs [NS][3];
  logic [2:0] neg [NS];
  box_t bx [NS];

  logic signed [15:0] ang [3];
  logic signed [TRIG_W-1:0] zf [3];
  logic [2:0] nf;

  assign ang[0] = box_data.pitch_angle;
  assign ang[1] = box_data.yaw_angle;
  assign ang[2] = box_data.roll_angle;

  always_comb begin
    en[NS-1] = !v[NS-1] || trig_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end
  assign box_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= box_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  // fold into [-pi/2, pi/2]; angle scaled up by 2^15
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [TRIG_W-1:0] za;
      za = {ang[l][15], ang[l], 15'd0};
      if (za > ANG_HALF_PI) begin
        zf[l] = za - ANG_PI;
        nf[l] = 1'b1;
      end else if (za < -ANG_HALF_PI) begin
        zf[l] = za + ANG_PI;
        nf[l] = 1'b1;
      end else begin
        zf[l] = za;
        nf[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bx[0]  <= box_data;
      neg[0] <= nf;
      for (int l = 0; l < 3; l++) begin
        xs[0][l] <= CORDIC_GAIN_INV;
        ys[0][l] <= '0;
        zs[0][l] <= zf[l];
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[s]) begin
        bx[s]  <= bx[s-1];
        neg[s] <= neg[s-1];
        for (int l = 0; l < 3; l++) begin
          if (zs[s-1][l] >= 0) begin
            xs[s][l] <= xs[s-1][l] - (ys[s-1][l] >>> (s - 1));
            ys[s][l] <= ys[s-1][l] + (xs[s-1][l] >>> (s - 1));
            zs[s][l] <= zs[s-1][l] - atan_val(s - 1);
          end else begin
            xs[s][l] <= xs[s-1][l] + (ys[s-1][l] >>> (s - 1));
            ys[s][l] <= ys[s-1][l] - (xs[s-1][l] >>> (s - 1));
            zs[s][l] <= zs[s-1][l] + atan_val(s - 1);
          end
        end
      end
    end
  end

  assign trig_valid   = v[NS-1];
  assign trig_data.sp = neg[NS-1][0] ? -ys[NS-1][0] : ys[NS-1][0];
  assign trig_data.cp = neg[NS-1][0] ? -xs[NS-1][0] : xs[NS-1][0];
  assign trig_data.sy = neg[NS-1][1] ? -ys[NS-1][1] : ys[NS-1][1];
  assign trig_data.cy = neg[NS-1][1] ? -xs[NS-1][1] : xs[NS-1][1];
  assign trig_data.sr = neg[NS-1][2] ? -ys[NS-1][2] : ys[NS-1][2];
  assign trig_data.cr = neg[NS-1][2] ? -xs[NS-1][2] : xs[NS-1][2];
  assign trig_data.bx = bx[NS-1];

endmodule

// ===== rtl/euler_box_corner_transform.sv =====
`timescale 1ns / 1ps
// Euler box corner transform.
// Input channel box_valid/box_ready/box_data: one box per beat (three Euler
// angles, three half extents, a center). Output channel corner_valid/
// corner_ready/corner_data: eight corner beats per box, index 0..7 in order,
// last_corner set on index 7.
// The first corner of a box leaves after its input beat has passed through
// a 29-stage CORDIC for all three angles, three matrix stages, the corner
// sequencer, a sum stage and the output register; the rest follow one per
// cycle while corner_ready is high.
// Throughput: one corner beat per cycle while corner_ready is high, set by
// the corner sequencer that walks the eight corners over the single output
// channel. Boxes may be offered back to back; they queue in the pipeline.
// Reset clears every valid bit and the corner counter; payload is not reset.
// When the receiver drops corner_ready the stages fill up behind the output
// register and box_ready falls once no stage is free; nothing is lost.
module euler_box_corner_transform (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  output logic              box_ready,
  input  ebct_pkg::box_t    box_data,
  output logic              corner_valid,
  input  logic              corner_ready,
  output ebct_pkg::corner_t corner_data
);
  import ebct_pkg::*;

  localparam int WIDE = 66;
  localparam logic signed [WIDE-1:0] SAT_HI = (WIDE'(1) <<< (COORD_WIDTH - 1)) - WIDE'(1);
  localparam logic signed [WIDE-1:0] SAT_LO = -SAT_HI - WIDE'(1);

  logic  trig_valid;
  logic  trig_ready;
  trig_t trig_data;

  ebct_cordic u_cordic (
    .clk        (clk),
    .rst        (rst),
    .box_valid  (box_valid),
    .box_ready  (box_ready),
    .box_data   (box_data),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_data  (trig_data)
  );

  logic vm1, vm2, vm3, ve, vs1;
  logic en_m1, en_m2, en_m3, en_e, en_s1, en_s2;
  logic [2:0] k;

  // stage M1: two-factor products
  logic signed [TRIG_W-1:0] m1_spsy, m1_cpsy, m1_a00, m1_a01, m1_a12, m1_a22;
  logic signed [TRIG_W-1:0] m1_cpsr, m1_cpcr, m1_spsr, m1_spcr, m1_sy;
  logic signed [TRIG_W-1:0] m1_sr, m1_cr;
  box_t m1_bx;
  // stage M2: three-factor products
  logic signed [TRIG_W-1:0] m2_t1, m2_t2, m2_t3, m2_t4;
  logic signed [TRIG_W-1:0] m2_a00, m2_a01, m2_a12, m2_a22;
  logic signed [TRIG_W-1:0] m2_cpsr, m2_cpcr, m2_spsr, m2_spcr, m2_sy;
  box_t m2_bx;
  // stage M3: matrix
  logic signed [TRIG_W-1:0] r [3][3];
  box_t m3_bx;
  // stage E: row times extent products, held for eight corners
  logic signed [PROD_W-1:0] p [3][3];
  logic signed [31:0] e_cx, e_cy, e_cz;
  // stage S1: signed row sums
  logic signed [PROD_W-1:0] s1_sum [3];
  logic signed [31:0] s1_cx, s1_cy, s1_cz;
  logic [2:0] s1_k;

  logic signed [TRIG_W:0] hx [3];

  assign en_s2      = !corner_valid || corner_ready;
  assign en_s1      = !vs1 || en_s2;
  assign en_e       = !ve || (en_s1 && k == 3'd7);
  assign en_m3      = !vm3 || en_e;
  assign en_m2      = !vm2 || en_m3;
  assign en_m1      = !vm1 || en_m2;
  assign trig_ready = en_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1          <= 1'b0;
      vm2          <= 1'b0;
      vm3          <= 1'b0;
      ve           <= 1'b0;
      vs1          <= 1'b0;
      corner_valid <= 1'b0;
      k            <= '0;
    end else begin
      if (en_m1) vm1 <= trig_valid;
      if (en_m2) vm2 <= vm1;
      if (en_m3) vm3 <= vm2;
      if (en_e)  ve  <= vm3;
      if (en_s1) vs1 <= ve;
      if (en_s2) corner_valid <= vs1;
      if (ve && en_s1) k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m1) begin
      m1_spsy <= mulq(trig_data.sp, trig_data.sy);
      m1_cpsy <= mulq(trig_data.cp, trig_data.sy);
      m1_a00  <= mulq(trig_data.cy, trig_data.cr);
      m1_a01  <= mulq(trig_data.cy, trig_data.sr);
      m1_a12  <= mulq(trig_data.cy, trig_data.sp);
      m1_a22  <= mulq(trig_data.cp, trig_data.cy);
      m1_cpsr <= mulq(trig_data.cp, trig_data.sr);
      m1_cpcr <= mulq(trig_data.cp, trig_data.cr);
      m1_spsr <= mulq(trig_data.sp, trig_data.sr);
      m1_spcr <= mulq(trig_data.sp, trig_data.cr);
      m1_sy   <= trig_data.sy;
      m1_sr   <= trig_data.sr;
      m1_cr   <= trig_data.cr;
      m1_bx   <= trig_data.bx;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m2) begin
      m2_t1   <= mulq(m1_spsy, m1_cr);
      m2_t2   <= mulq(m1_spsy, m1_sr);
      m2_t3   <= mulq(m1_cpsy, m1_cr);
      m2_t4   <= mulq(m1_cpsy, m1_sr);
      m2_a00  <= m1_a00;
      m2_a01  <= m1_a01;
      m2_a12  <= m1_a12;
      m2_a22  <= m1_a22;
      m2_cpsr <= m1_cpsr;
      m2_cpcr <= m1_cpcr;
      m2_spsr <= m1_spsr;
      m2_spcr <= m1_spcr;
      m2_sy   <= m1_sy;
      m2_bx   <= m1_bx;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m3) begin
      r[0][0] <= m2_a00;
      r[0][1] <= m2_a01;
      r[0][2] <= -m2_sy;
      r[1][0] <= m2_t1 - m2_cpsr;
      r[1][1] <= m2_t2 + m2_cpcr;
      r[1][2] <= m2_a12;
      r[2][0] <= m2_t3 + m2_spsr;
      r[2][1] <= m2_t4 - m2_spcr;
      r[2][2] <= m2_a22;
      m3_bx   <= m2_bx;
    end
  end

  assign hx[0] = {2'b00, m3_bx.half_width};
  assign hx[1] = {2'b00, m3_bx.half_length};
  assign hx[2] = {2'b00, m3_bx.half_height};

  always_ff @(posedge clk) begin
    if (en_e) begin
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          p[row][col] <= PROD_W'(r[row][col]) * PROD_W'(hx[col]);
        end
      end
      e_cx <= m3_bx.center_x;
      e_cy <= m3_bx.center_y;
      e_cz <= m3_bx.center_z;
    end
  end

  // corner bit set means the plus sign on that axis
  always_ff @(posedge clk) begin
    if (en_s1) begin
      for (int row = 0; row < 3; row++) begin
        s1_sum[row] <= (k[0] ? p[row][0] : -p[row][0])
                     + (k[1] ? p[row][1] : -p[row][1])
                     + (k[2] ? p[row][2] : -p[row][2]);
      end
      s1_k  <= k;
      s1_cx <= e_cx;
      s1_cy <= e_cy;
      s1_cz <= e_cz;
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] place(input logic signed [PROD_W-1:0] sum,
                                                         input logic signed [31:0] c);
    logic signed [PROD_W-1:0] t;
    logic signed [WIDE-1:0]   w;
    t = sum + ROUND_HALF;
    w = WIDE'($signed(t[PROD_W-1:TRIG_FRAC])) + WIDE'(c);
    if (w > SAT_HI) w = SAT_HI;
    if (w < SAT_LO) w = SAT_LO;
    return w[COORD_WIDTH-1:0];
  endfunction

  // row 1 drives x, row 0 drives y
  always_ff @(posedge clk) begin
    if (en_s2) begin
      corner_data.corner_index <= s1_k;
      corner_data.corner_x     <= place(s1_sum[1], s1_cx);
      corner_data.corner_y     <= place(s1_sum[0], s1_cy);
      corner_data.corner_z     <= place(s1_sum[2], s1_cz);
      corner_data.last_corner  <= (s1_k == 3'd7);
    end
  end

  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    !ve |-> k == 3'd0)
    else $error("corner counter not at zero while sequencer empty");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_ready && !corner_data.last_corner |=>
      corner_valid && corner_data.corner_index != 3'd0)
    else $error("corner run broken before last corner");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    ve && en_s1 && k != 3'd7 |=> ve && k == $past(k) + 3'd1)
    else $error("corner sequencer skipped or lost a box");

endmodule
